// ===== hw/rtl/kss_pkg.sv =====
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants of the key slot store: command codes, the
// request broadcast to the slot cells, the action bus and the scan token.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int KSS_ENTRIES    = 16;
    localparam int KSS_NAME_BYTES = 8;
    localparam int KSS_DATA_BYTES = 32;

    localparam int KSS_IDX_W  = 8;
    localparam int KSS_CNT_W  = 9;
    localparam int KSS_APP_W  = 16;
    localparam int KSS_NAME_W = 64;
    localparam int KSS_DATA_W = 256;

    localparam logic [2:0] KSS_CMD_ADD      = 3'd0;
    localparam logic [2:0] KSS_CMD_GET_NAME = 3'd1;
    localparam logic [2:0] KSS_CMD_GET_IDX  = 3'd2;
    localparam logic [2:0] KSS_CMD_DELETE   = 3'd3;
    localparam logic [2:0] KSS_CMD_WIPE     = 3'd4;
    localparam logic [2:0] KSS_CMD_CLEAR    = 3'd5;
    localparam logic [2:0] KSS_CMD_PRELOAD  = 3'd6;
    localparam logic [2:0] KSS_CMD_NOP      = 3'd7;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [KSS_APP_W-1:0]  app;
        logic [KSS_NAME_W-1:0] name;
        logic [KSS_IDX_W-1:0]  slot_idx;
        logic [KSS_CNT_W-1:0]  siu;
    } kss_req_t;

    typedef struct packed {
        logic                 clear;
        logic                 fill;
        logic                 free;
        logic                 locked;
        logic [KSS_IDX_W-1:0] idx;
    } kss_act_t;

    typedef struct packed {
        logic                  valid;
        logic                  match_ok;
        logic [KSS_IDX_W-1:0]  match_idx;
        logic                  match_locked;
        logic [KSS_NAME_W-1:0] match_name;
        logic                  free_ok;
        logic [KSS_IDX_W-1:0]  free_idx;
        logic                  idx_ok;
        logic                  idx_locked;
        logic [KSS_NAME_W-1:0] idx_name;
        logic [KSS_CNT_W-1:0]  freed;
    } kss_tok_t;

endpackage

// ===== hw/rtl/kss_cell.sv =====
// ----------------------------------------------------------------------------
// kss_cell
// One key slot: used/owner/read-only marks and the name. Checks the passing
// scan token against its slot and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module kss_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  kss_pkg::kss_req_t req,
    input  kss_pkg::kss_act_t act,
    input  kss_pkg::kss_tok_t tok_in,
    output kss_pkg::kss_tok_t tok_out
);

    localparam logic [kss_pkg::KSS_IDX_W-1:0] MY_IDX = kss_pkg::KSS_IDX_W'(CELL_IDX);

    logic                            used_reg;
    logic [kss_pkg::KSS_APP_W-1:0]   owner_reg;
    logic                            locked_reg;
    logic [kss_pkg::KSS_NAME_W-1:0]  name_reg;
    kss_pkg::kss_tok_t               tok_reg;
    kss_pkg::kss_tok_t               tok_next;
    logic                            active;
    logic                            owned;
    logic                            hit;
    logic                            wipe_me;
    logic                            target;

    assign active  = {1'b0, MY_IDX} < req.siu;
    assign owned   = active && used_reg && (owner_reg == req.app);
    assign hit     = owned && (name_reg == req.name);
    assign wipe_me = tok_in.valid && (req.cmd == kss_pkg::KSS_CMD_WIPE) && active
                     && used_reg && !locked_reg;
    assign target  = (act.idx == MY_IDX);

    always_comb begin
        tok_next = tok_in;
        if (!tok_in.match_ok && hit) begin
            tok_next.match_ok     = 1'b1;
            tok_next.match_idx    = MY_IDX;
            tok_next.match_locked = locked_reg;
            tok_next.match_name   = name_reg;
        end
        if (!tok_in.free_ok && active && !used_reg) begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
        if (owned && (req.slot_idx == MY_IDX)) begin
            tok_next.idx_ok     = 1'b1;
            tok_next.idx_locked = locked_reg;
            tok_next.idx_name   = name_reg;
        end
        if (wipe_me) begin
            tok_next.freed = tok_in.freed + kss_pkg::KSS_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= 1'b0;
            owner_reg  <= '0;
            locked_reg <= 1'b0;
            tok_reg    <= '0;
        end else begin
            tok_reg <= tok_next;
            priority if (act.clear) begin
                used_reg   <= 1'b0;
                owner_reg  <= '0;
                locked_reg <= 1'b0;
            end else if (wipe_me) begin
                used_reg  <= 1'b0;
                owner_reg <= '0;
            end else if (act.fill && target) begin
                used_reg   <= 1'b1;
                owner_reg  <= req.app;
                locked_reg <= act.locked;
            end else if (act.free && target) begin
                used_reg  <= 1'b0;
                owner_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (act.fill && target && !act.clear) begin
            name_reg <= req.name;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hw/rtl/key_slot_store.sv =====
// ----------------------------------------------------------------------------
// key_slot_store
// Slot table of application-owned keys with name, data and read-only mark.
// A scan token walks the row of slot cells; the decision is taken at its end.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | contents
//  s_       | in  | s_tvalid / s_tready    | one command transfer
//  m_       | out | m_tvalid / m_tready    | one result transfer per command
//  apb      | in  | psel/penable/pwrite    | slots_in_use @0x0, app id limit @0x4
//
//  Each command is latched, its token passes the cell row, the decision is
//  taken and the data memory read, and then the output register is loaded.
//  A new command is taken once the result sits in the output register; a
//  stalled result holds the next one in the last step.
//  Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_slot_store #(
    parameter int ENTRIES    = kss_pkg::KSS_ENTRIES,
    parameter int NAME_BYTES = kss_pkg::KSS_NAME_BYTES,
    parameter int DATA_BYTES = kss_pkg::KSS_DATA_BYTES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0] app_id[18:3] key_name[82:19] slot_index[90:83]
    // key_data0[154:91] key_data1[218:155] key_data2[282:219] key_data3[346:283]
    input  logic [351:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[0] found_slot[5:1] is_read_only[6] out_name[70:7]
    // out_data0[134:71] out_data1[198:135] out_data2[262:199] out_data3[326:263]
    output logic [327:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = kss_pkg::KSS_CNT_W;
    localparam int DW = kss_pkg::KSS_DATA_W;
    localparam int NW = kss_pkg::KSS_NAME_W;
    localparam logic [NW-1:0] NAME_MASK = {NW{1'b1}} >> (NW - 8 * NAME_BYTES);
    localparam logic [DW-1:0] DATA_MASK = {DW{1'b1}} >> (DW - 8 * DATA_BYTES);
    localparam logic [CW-1:0] SIU_MAX   = CW'(ENTRIES);
    localparam logic [CW-1:0] SIU_RST   = CW'((ENTRIES < 16) ? ENTRIES : 16);

    localparam logic [2:0] ADDR_SIU   = 3'd0;
    localparam logic [2:0] ADDR_MAXID = 3'd4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic                           start_reg;
    logic [CW-1:0]                  siu_reg;
    logic [15:0]                    maxid_reg;
    logic [CW-1:0]                  free_cnt_reg;
    logic [CW-1:0]                  free_cnt_next;
    logic [2:0]                     cmd_reg;
    logic [15:0]                    app_reg;
    logic [NW-1:0]                  name_reg;
    logic [7:0]                     idx_reg;
    logic [DW-1:0]                  data_reg;
    logic [DW-1:0]                  mem [ENTRIES];
    logic [DW-1:0]                  rd_data_reg;
    logic                           res_ok_reg;
    logic [4:0]                     res_slot_reg;
    logic                           res_locked_reg;
    logic [NW-1:0]                  res_name_reg;
    logic                           res_entry_reg;
    logic                           m_tvalid_reg;
    logic [327:0]                   m_tdata_reg;

    kss_pkg::kss_req_t              req;
    kss_pkg::kss_act_t              act;
    kss_pkg::kss_tok_t              tok_chain [ENTRIES+1];
    kss_pkg::kss_tok_t              tok_end;
    logic [ENTRIES-1:0]             tok_valid_vec;

    logic                           s_accept;
    logic                           cfg_wr;
    logic                           cfg_siu_wr;
    logic [CW-1:0]                  cfg_siu_val;
    logic                           decide;
    logic                           app_ok;
    logic                           dec_ok;
    logic [kss_pkg::KSS_IDX_W-1:0]  dec_slot;
    logic                           dec_use_slot;
    logic                           dec_entry;
    logic                           dec_locked;
    logic [NW-1:0]                  dec_name;
    logic [kss_pkg::KSS_IDX_W-1:0]  dec_rd_idx;
    logic                           dec_clear;
    logic                           out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_siu_wr  = cfg_wr && (paddr == ADDR_SIU);
    assign cfg_siu_val = ({4'b0, pwdata[4:0]} > SIU_MAX) ? SIU_MAX : {4'b0, pwdata[4:0]};

    always_comb begin
        unique case (paddr)
            ADDR_SIU:   prdata = {{(32 - CW){1'b0}}, siu_reg};
            ADDR_MAXID: prdata = {16'b0, maxid_reg};
            default:    prdata = '0;
        endcase
    end

    assign req.cmd      = cmd_reg;
    assign req.app      = app_reg;
    assign req.name     = name_reg;
    assign req.slot_idx = idx_reg;
    assign req.siu      = siu_reg;

    always_comb begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = start_reg;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kss_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (req),
            .act     (act),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
        assign tok_valid_vec[g] = tok_chain[g+1].valid;
    end

    assign tok_end = tok_chain[ENTRIES];
    assign decide  = (state_reg == ST_SCAN) && tok_end.valid;
    assign app_ok  = (app_reg <= maxid_reg);

    always_comb begin
        dec_ok        = 1'b0;
        dec_slot      = '0;
        dec_use_slot  = 1'b0;
        dec_entry     = 1'b0;
        dec_locked    = 1'b0;
        dec_name      = '0;
        dec_rd_idx    = tok_end.match_idx;
        dec_clear     = 1'b0;
        act.fill      = 1'b0;
        act.free      = 1'b0;
        act.locked    = 1'b0;
        act.idx       = tok_end.free_idx;
        free_cnt_next = free_cnt_reg;
        unique case (cmd_reg)
            kss_pkg::KSS_CMD_ADD: begin
                if (app_ok && (free_cnt_reg != '0) && !tok_end.match_ok
                        && tok_end.free_ok) begin
                    dec_ok        = 1'b1;
                    dec_use_slot  = 1'b1;
                    dec_slot      = tok_end.free_idx;
                    act.fill      = 1'b1;
                    free_cnt_next = free_cnt_reg - CW'(1);
                end
            end
            kss_pkg::KSS_CMD_GET_NAME: begin
                if (app_ok && tok_end.match_ok) begin
                    dec_ok       = 1'b1;
                    dec_use_slot = 1'b1;
                    dec_slot     = tok_end.match_idx;
                    dec_entry    = 1'b1;
                    dec_locked   = tok_end.match_locked;
                    dec_name     = tok_end.match_name;
                end
            end
            kss_pkg::KSS_CMD_GET_IDX: begin
                dec_rd_idx = idx_reg;
                if (app_ok && tok_end.idx_ok) begin
                    dec_ok       = 1'b1;
                    dec_use_slot = 1'b1;
                    dec_slot     = idx_reg;
                    dec_entry    = 1'b1;
                    dec_locked   = tok_end.idx_locked;
                    dec_name     = tok_end.idx_name;
                end
            end
            kss_pkg::KSS_CMD_DELETE: begin
                act.idx = tok_end.match_idx;
                if (app_ok && tok_end.match_ok && !tok_end.match_locked) begin
                    dec_ok        = 1'b1;
                    dec_use_slot  = 1'b1;
                    dec_slot      = tok_end.match_idx;
                    act.free      = 1'b1;
                    free_cnt_next = free_cnt_reg + CW'(1);
                end
            end
            kss_pkg::KSS_CMD_WIPE: begin
                dec_ok        = 1'b1;
                free_cnt_next = free_cnt_reg + tok_end.freed;
            end
            kss_pkg::KSS_CMD_CLEAR: begin
                dec_ok    = 1'b1;
                dec_clear = 1'b1;
            end
            kss_pkg::KSS_CMD_PRELOAD: begin
                if ((free_cnt_reg == '0) || !tok_end.free_ok || tok_end.match_ok) begin
                    dec_clear = 1'b1;
                end else begin
                    dec_ok        = 1'b1;
                    dec_use_slot  = 1'b1;
                    dec_slot      = tok_end.free_idx;
                    act.fill      = 1'b1;
                    act.locked    = 1'b1;
                    free_cnt_next = free_cnt_reg - CW'(1);
                end
            end
            kss_pkg::KSS_CMD_NOP: begin
                dec_ok = 1'b1;
            end
            default: begin
                dec_ok = 1'b1;
            end
        endcase
        if (dec_clear) begin
            free_cnt_next = siu_reg;
        end
        if (!decide) begin
            act.fill = 1'b0;
            act.free = 1'b0;
        end
        act.clear = cfg_siu_wr || (decide && dec_clear);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_SCAN;
            ST_SCAN: if (tok_end.valid) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            siu_reg      <= SIU_RST;
            maxid_reg    <= 16'hFFFF;
            free_cnt_reg <= SIU_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_accept;
            if (cfg_siu_wr) begin
                siu_reg      <= cfg_siu_val;
                free_cnt_reg <= cfg_siu_val;
            end else if (decide) begin
                free_cnt_reg <= free_cnt_next;
            end
            if (cfg_wr && (paddr == ADDR_MAXID)) begin
                maxid_reg <= pwdata[15:0];
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tdata[2:0];
            app_reg  <= s_tdata[18:3];
            name_reg <= s_tdata[82:19] & NAME_MASK;
            idx_reg  <= s_tdata[90:83];
            data_reg <= s_tdata[346:91] & DATA_MASK;
        end
        if (decide) begin
            res_ok_reg     <= dec_ok;
            res_slot_reg   <= dec_use_slot ? dec_slot[4:0] : siu_reg[4:0];
            res_locked_reg <= dec_locked;
            res_name_reg   <= dec_name;
            res_entry_reg  <= dec_entry;
            rd_data_reg    <= mem[dec_rd_idx[IW-1:0]];
        end
        if (act.fill) begin
            mem[act.idx[IW-1:0]] <= data_reg;
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= {1'b0,
                            res_entry_reg ? rd_data_reg : {DW{1'b0}},
                            res_name_reg,
                            res_locked_reg,
                            res_slot_reg,
                            !res_ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_free_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= siu_reg)
        else $error("free count above table size");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid_vec))
        else $error("more than one scan token in the cell row");

    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[5:1] == siu_reg[4:0]))
        else $error("failed command reports a slot");

endmodule
